// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold on every clock outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/ctsw_pkg.sv =====
// ---------------------------------------------------------------------------
// ctsw_pkg
// Shared types and constants of the countdown time switch.
// ---------------------------------------------------------------------------
package ctsw_pkg;

   localparam int MAX_HOURS_DEFAULT = 99;
   localparam logic [5:0] UNIT_TOP = 6'd59;

   typedef enum logic [2:0] {
      CMD_TICK         = 3'd0,
      CMD_HOURS_UP     = 3'd1,
      CMD_HOURS_DOWN   = 3'd2,
      CMD_MINUTES_UP   = 3'd3,
      CMD_MINUTES_DOWN = 3'd4,
      CMD_SECONDS_UP   = 3'd5,
      CMD_SECONDS_DOWN = 3'd6
   } command_type;

   typedef struct packed {
      logic [6:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       relay;
   } count_type;

endpackage

// ===== src/ctsw_channel_if.sv =====
// ---------------------------------------------------------------------------
// ctsw request and response channels
// Valid/ready interfaces carrying the command and the count readout.
// ---------------------------------------------------------------------------
interface ctsw_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic       run_enable;

   modport source (output valid, output command, output run_enable, input ready);
   modport sink   (input valid, input command, input run_enable, output ready);
endinterface

interface ctsw_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] hours_now;
   logic [5:0] minutes_now;
   logic [5:0] seconds_now;
   logic       relay_on;
   logic       expired;

   modport source (output valid, output hours_now, output minutes_now,
                   output seconds_now, output relay_on, output expired,
                   input ready);
   modport sink   (input valid, input hours_now, input minutes_now,
                   input seconds_now, input relay_on, input expired,
                   output ready);
endinterface

// ===== src/ctsw_update.sv =====
// ---------------------------------------------------------------------------
// ctsw_update
// Next count and relay state for one command.
// ---------------------------------------------------------------------------
module ctsw_update #(
   parameter int MAX_HOURS = ctsw_pkg::MAX_HOURS_DEFAULT
) (
   input  ctsw_pkg::count_type count_cur,
   input  logic [2:0]          command,
   input  logic                run_enable,
   input  logic                start_on,
   output ctsw_pkg::count_type count_nxt,
   output logic                expired
);

   localparam logic [6:0] MaxHours = 7'(MAX_HOURS);

   function automatic logic [6:0] raise_hours(input logic [6:0] h);
      if (h < MaxHours) begin
         return h + 7'd1;
      end else begin
         return MaxHours;
      end
   endfunction

   always_comb begin
      count_nxt = count_cur;
      expired   = 1'b0;
      unique case (command)
         ctsw_pkg::CMD_TICK: begin
            if (!run_enable) begin
               count_nxt.relay = 1'b0;
            end else if (count_cur.seconds != 6'd0) begin
               count_nxt.relay   = start_on;
               count_nxt.seconds = count_cur.seconds - 6'd1;
            end else if (count_cur.minutes != 6'd0) begin
               count_nxt.relay   = start_on;
               count_nxt.minutes = count_cur.minutes - 6'd1;
               count_nxt.seconds = ctsw_pkg::UNIT_TOP;
            end else if (count_cur.hours != 7'd0) begin
               count_nxt.relay   = start_on;
               count_nxt.hours   = count_cur.hours - 7'd1;
               count_nxt.minutes = ctsw_pkg::UNIT_TOP;
               count_nxt.seconds = ctsw_pkg::UNIT_TOP;
            end else begin
               count_nxt.relay = ~start_on;
               expired         = 1'b1;
            end
         end
         ctsw_pkg::CMD_HOURS_UP: begin
            count_nxt.hours = raise_hours(count_cur.hours);
         end
         ctsw_pkg::CMD_HOURS_DOWN: begin
            if (count_cur.hours != 7'd0) begin
               count_nxt.hours = count_cur.hours - 7'd1;
            end
         end
         ctsw_pkg::CMD_MINUTES_UP: begin
            if (count_cur.minutes >= ctsw_pkg::UNIT_TOP) begin
               count_nxt.minutes = 6'd0;
               count_nxt.hours   = raise_hours(count_cur.hours);
            end else begin
               count_nxt.minutes = count_cur.minutes + 6'd1;
            end
         end
         ctsw_pkg::CMD_MINUTES_DOWN: begin
            if (count_cur.minutes != 6'd0) begin
               count_nxt.minutes = count_cur.minutes - 6'd1;
            end
         end
         ctsw_pkg::CMD_SECONDS_UP: begin
            if (count_cur.seconds >= ctsw_pkg::UNIT_TOP) begin
               count_nxt.seconds = 6'd0;
               // carry ripples through minutes into hours
               if (count_cur.minutes >= ctsw_pkg::UNIT_TOP) begin
                  count_nxt.minutes = 6'd0;
                  count_nxt.hours   = raise_hours(count_cur.hours);
               end else begin
                  count_nxt.minutes = count_cur.minutes + 6'd1;
               end
            end else begin
               count_nxt.seconds = count_cur.seconds + 6'd1;
            end
         end
         ctsw_pkg::CMD_SECONDS_DOWN: begin
            if (count_cur.seconds != 6'd0) begin
               count_nxt.seconds = count_cur.seconds - 6'd1;
            end
         end
         default: begin
            // unused code: no change
         end
      endcase
   end

endmodule

// ===== src/countdown_time_switch.sv =====
// ---------------------------------------------------------------------------
// countdown_time_switch
// Hours:minutes:seconds countdown with relay drive, valid/ready channels.
// ---------------------------------------------------------------------------
// Each request carries one command: a tick (counts down one second with
// borrow when run_enable is set, turns the relay off otherwise) or a button
// press that raises or lowers hours, minutes or seconds. Raising seconds or
// minutes past 59 wraps to 0 and carries; hours saturate at MAX_HOURS;
// lowering clamps at 0. Every request produces exactly one response holding
// the count after the update, the relay drive and the expired flag. The
// relay follows csr start_on while counting and its inverse once a running
// tick finds the count at zero (that tick also raises expired). Throughput
// is one request per clock unless the output stalls; the response appears
// in the output register in the cycle after acceptance. The count registers
// are updated at acceptance, so the combinational state update path is what
// sets this rate. req ready stays high while the output register is empty
// or being drained in the same cycle. start_on resets to 1; the user must
// write it with csr_write_enable only while the block is idle (unenforced).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module countdown_time_switch #(
   parameter int MAX_HOURS = ctsw_pkg::MAX_HOURS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ctsw_req_if.sink    req_bus,
   ctsw_rsp_if.source  rsp_bus,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   // control register
   logic start_on_ff;

   // live count state
   ctsw_pkg::count_type count_ff;
   ctsw_pkg::count_type count_in;
   logic                expired_in;

   // response register
   logic                rsp_valid_ff;
   ctsw_pkg::count_type rsp_count_ff;
   logic                rsp_expired_ff;

   logic req_accept;
   logic rsp_accept;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_accept    = rsp_valid_ff && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_on_ff <= 1'b1;
      end else if (csr_write_enable) begin
         start_on_ff <= csr_write_data;
      end
   end

   ctsw_update #(
      .MAX_HOURS (MAX_HOURS)
   ) u_update (
      .count_cur  (count_ff),
      .command    (req_bus.command),
      .run_enable (req_bus.run_enable),
      .start_on   (start_on_ff),
      .count_nxt  (count_in),
      .expired    (expired_in)
   );

   // count state moves only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_accept) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_count_ff   <= count_in;
         rsp_expired_ff <= expired_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.hours_now   = rsp_count_ff.hours;
   assign rsp_bus.minutes_now = rsp_count_ff.minutes;
   assign rsp_bus.seconds_now = rsp_count_ff.seconds;
   assign rsp_bus.relay_on    = rsp_count_ff.relay;
   assign rsp_bus.expired     = rsp_expired_ff;

   // ---- checks ----
   `ASSERT_ALWAYS(a_count_range, clock, reset,
      (count_ff.seconds <= ctsw_pkg::UNIT_TOP) && (count_ff.minutes <= ctsw_pkg::UNIT_TOP)
      && (count_ff.hours <= 7'(MAX_HOURS)))
   `ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_accept, rsp_valid_ff)
   `ASSERT_IMPLY(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_bus.ready, !req_bus.ready)
   `ASSERT_IMPLY(a_expired_at_zero, clock, reset, rsp_valid_ff && rsp_expired_ff,
      (rsp_count_ff.hours == 7'd0) && (rsp_count_ff.minutes == 6'd0)
      && (rsp_count_ff.seconds == 6'd0) && (rsp_count_ff.relay == !start_on_ff))

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the countdown time switch: table-driven directed
// requests, then burst-shaped random traffic under three idle profiles with
// a long response hold-off, every response checked against model or table.
// ---------------------------------------------------------------------------
module testbench;

   // command code the block must ignore
   localparam logic [2:0] CMD_SPARE = 3'd7;
   localparam int HOUR_LIMIT  = ctsw_pkg::MAX_HOURS_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PER_PHASE = 250;

   // one response: the count after the update plus the expired flag
   typedef struct packed {
      ctsw_pkg::count_type count;
      logic                expired;
   } readout_type;

   // one request; golden_on marks a table row whose response is typed in
   typedef struct packed {
      logic [2:0] cmd;
      logic       run;
      logic       golden_on;
      logic [6:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       relay;
      logic       expired;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   logic csr_write_data;

   ctsw_req_if req_bus ();
   ctsw_rsp_if rsp_bus ();

   countdown_time_switch u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // Directed table, start_on at its reset value of 1. Rows with golden_on
   // set carry a response read straight off the spec; the rest go through
   // the model. Walks through clamping at zero, expiry, the ignored code,
   // hour borrow (minutes and seconds both to 59) and a double carry.
   request_type directed_rows [20] = '{
      '{ctsw_pkg::CMD_TICK,         1'b0, 1'b1, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_TICK,         1'b1, 1'b1, 7'd0, 6'd0,  6'd0,  1'b0, 1'b1},
      '{ctsw_pkg::CMD_SECONDS_DOWN, 1'b0, 1'b1, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_MINUTES_DOWN, 1'b1, 1'b1, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_HOURS_DOWN,   1'b0, 1'b1, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{CMD_SPARE,                  1'b1, 1'b1, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_HOURS_UP,     1'b0, 1'b1, 7'd1, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_TICK,         1'b1, 1'b1, 7'd0, 6'd59, 6'd59, 1'b1, 1'b0},
      '{ctsw_pkg::CMD_SECONDS_UP,   1'b1, 1'b0, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_SECONDS_UP,   1'b0, 1'b0, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{CMD_SPARE,                  1'b0, 1'b0, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_TICK,         1'b1, 1'b0, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_TICK,         1'b1, 1'b0, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_MINUTES_UP,   1'b0, 1'b0, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_MINUTES_DOWN, 1'b1, 1'b0, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_SECONDS_DOWN, 1'b0, 1'b0, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_TICK,         1'b0, 1'b0, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_HOURS_DOWN,   1'b1, 1'b0, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_TICK,         1'b1, 1'b0, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0},
      '{ctsw_pkg::CMD_HOURS_UP,     1'b1, 1'b0, 7'd0, 6'd0,  6'd0,  1'b0, 1'b0}
   };

   // model state, kept in step with the block at each accepted request
   ctsw_pkg::count_type model_count;
   logic                model_start_on;
   readout_type         expected_readouts [$];
   request_type         pending_requests [$];
   request_type         driven_request;

   int  send_idle_pct;
   int  recv_idle_pct;
   int  stall_left;
   int  requests_queued;
   int  responses_seen;
   int  fail_count;
   int  cycle_count;
   int  expiries_seen;
   int  hours_peak;
   bit  req_fire;

   // -------------------------------------------------------------------------
   // Model of the count. Raising wraps minutes and seconds past 59 with a
   // carry; hours saturate. Lowering clamps at zero with no borrow.
   // -------------------------------------------------------------------------
   function automatic void bump_hours();
      if (model_count.hours < HOUR_LIMIT) begin
         model_count.hours = model_count.hours + 7'd1;
      end else begin
         model_count.hours = HOUR_LIMIT[6:0];
      end
   endfunction

   function automatic void bump_minutes();
      if (model_count.minutes >= ctsw_pkg::UNIT_TOP) begin
         model_count.minutes = '0;
         bump_hours();
      end else begin
         model_count.minutes = model_count.minutes + 6'd1;
      end
   endfunction

   function automatic readout_type step_countdown(input logic [2:0] cmd, input logic run);
      readout_type result;
      result.expired = 1'b0;
      unique case (cmd)
         ctsw_pkg::CMD_TICK: begin
            // a stopped tick drops the relay; a running one counts down
            // with borrow, or flags expiry and inverts the relay at zero
            if (!run) begin
               model_count.relay = 1'b0;
            end else if (model_count.seconds != 0) begin
               model_count.relay   = model_start_on;
               model_count.seconds = model_count.seconds - 6'd1;
            end else if (model_count.minutes != 0) begin
               model_count.relay   = model_start_on;
               model_count.minutes = model_count.minutes - 6'd1;
               model_count.seconds = ctsw_pkg::UNIT_TOP;
            end else if (model_count.hours != 0) begin
               model_count.relay   = model_start_on;
               model_count.hours   = model_count.hours - 7'd1;
               model_count.minutes = ctsw_pkg::UNIT_TOP;
               model_count.seconds = ctsw_pkg::UNIT_TOP;
            end else begin
               model_count.relay = ~model_start_on;
               result.expired    = 1'b1;
            end
         end
         ctsw_pkg::CMD_HOURS_UP:   bump_hours();
         ctsw_pkg::CMD_HOURS_DOWN: begin
            if (model_count.hours != 0) model_count.hours = model_count.hours - 7'd1;
         end
         ctsw_pkg::CMD_MINUTES_UP: bump_minutes();
         ctsw_pkg::CMD_MINUTES_DOWN: begin
            if (model_count.minutes != 0) model_count.minutes = model_count.minutes - 6'd1;
         end
         ctsw_pkg::CMD_SECONDS_UP: begin
            if (model_count.seconds >= ctsw_pkg::UNIT_TOP) begin
               model_count.seconds = '0;
               bump_minutes();
            end else begin
               model_count.seconds = model_count.seconds + 6'd1;
            end
         end
         ctsw_pkg::CMD_SECONDS_DOWN: begin
            if (model_count.seconds != 0) model_count.seconds = model_count.seconds - 6'd1;
         end
         default: ; // spare code: nothing moves
      endcase
      result.count = model_count;
      return result;
   endfunction

   // -------------------------------------------------------------------------
   // Scoreboard, on the rising edge. Requests are predicted before responses
   // are popped, so the order holds even for a response in its request's cycle.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      readout_type predicted;
      readout_type wanted;
      readout_type seen;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         req_fire = req_bus.valid && req_bus.ready;
         if (reset) begin
            model_count    = '0;
            model_start_on = 1'b1;
         end else begin
            if (csr_write_enable) model_start_on = csr_write_data;
            if (req_fire) begin
               predicted = step_countdown(driven_request.cmd, driven_request.run);
               // a typed-in row overrides the model's answer
               if (driven_request.golden_on) begin
                  wanted = '{'{driven_request.hours, driven_request.minutes,
                               driven_request.seconds, driven_request.relay},
                             driven_request.expired};
               end else begin
                  wanted = predicted;
               end
               expected_readouts.push_back(wanted);
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
               responses_seen++;
               seen = '{'{rsp_bus.hours_now, rsp_bus.minutes_now, rsp_bus.seconds_now,
                          rsp_bus.relay_on}, rsp_bus.expired};
               if (expected_readouts.size() == 0) begin
                  fail_count++;
                  $display("%0t: response with nothing expected, got %0d:%0d:%0d %s",
                           $time, seen.count.hours, seen.count.minutes,
                           seen.count.seconds,
                           $sformatf("relay %b expired %b", seen.count.relay,
                                     seen.expired));
               end else begin
                  wanted = expected_readouts.pop_front();
                  if (seen !== wanted) begin
                     fail_count++;
                     $display("%0t: mismatch, expected %0d:%0d:%0d relay %b expired %b, %s",
                              $time, wanted.count.hours, wanted.count.minutes,
                              wanted.count.seconds, wanted.count.relay, wanted.expired,
                              $sformatf("got %0d:%0d:%0d relay %b expired %b",
                                        seen.count.hours, seen.count.minutes,
                                        seen.count.seconds, seen.count.relay,
                                        seen.expired));
                  end
                  if (wanted.expired) expiries_seen++;
                  if (int'(wanted.count.hours) > hours_peak) begin
                     hours_peak = int'(wanted.count.hours);
                  end
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request driver, on the falling edge: takes the next queued request once
   // the slot is free, or idles at the current rate. valid gets one update
   // per edge, so back-to-back requests keep it high.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : request_driver
      if (!reset && (!req_bus.valid || req_fire)) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            driven_request     <= pending_requests[0];
            req_bus.command    <= pending_requests[0].cmd;
            req_bus.run_enable <= pending_requests[0].run;
            req_bus.valid      <= 1'b1;
            pending_requests.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response side: random stalls plus a long hold-off counted down here.
   always @(negedge clock) begin : response_sink
      if (stall_left != 0) stall_left <= stall_left - 1;
      rsp_bus.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic queue_request(input logic [2:0] cmd, input logic run);
      request_type req;
      req           = '0;
      req.cmd       = cmd;
      req.run       = run;
      pending_requests.push_back(req);
      requests_queued++;
   endtask

   // Random traffic in bursts: long button runs push hours to saturation,
   // force carries and clamp units to zero; tick runs count down and expire;
   // single requests mix in every code, the spare one too.
   task automatic queue_random(input int total);
      int         made;
      int         kind;
      int         len;
      logic [2:0] cmd;
      made = 0;
      while (made < total) begin
         kind = $urandom_range(99);
         if (kind < 12) begin
            cmd = 3'($urandom_range(ctsw_pkg::CMD_SECONDS_DOWN, ctsw_pkg::CMD_HOURS_UP));
            if (cmd == ctsw_pkg::CMD_HOURS_UP || cmd == ctsw_pkg::CMD_HOURS_DOWN) begin
               len = $urandom_range(120, 20);
            end else begin
               len = $urandom_range(70, 10);
            end
            repeat (len) queue_request(cmd, 1'($urandom_range(1)));
            made += len;
         end else if (kind < 60) begin
            len = $urandom_range(40, 1);
            repeat (len) queue_request(ctsw_pkg::CMD_TICK, $urandom_range(9) != 0);
            made += len;
         end else begin
            cmd = 3'($urandom_range(7));
            queue_request(cmd, 1'($urandom_range(1)));
            if (cmd != CMD_SPARE) made++;
         end
      end
   endtask

   // every request yields one response, so this means the block is idle
   task automatic wait_drained();
      while (responses_seen != requests_queued) @(negedge clock);
   endtask

   task automatic write_start_on(input logic value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.command    = ctsw_pkg::CMD_TICK;
      req_bus.run_enable = 1'b0;
      rsp_bus.ready      = 1'b0;
      csr_write_enable   = 1'b0;
      csr_write_data     = 1'b0;
      driven_request     = '0;
      send_idle_pct      = 28;
      recv_idle_pct      = 66;
      stall_left         = 0;
      requests_queued    = 0;
      responses_seen     = 0;
      fail_count         = 0;
      cycle_count        = 0;
      expiries_seen      = 0;
      hours_peak         = 0;
      req_fire           = 1'b0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed table, start_on still at its reset value
      foreach (directed_rows[i]) begin
         pending_requests.push_back(directed_rows[i]);
         requests_queued++;
      end
      wait_drained();

      // phase 1: slow receiver side, relay inverted polarity
      write_start_on(1'b0);
      queue_random(RANDOM_PER_PHASE);
      wait_drained();

      // phase 2: idling swapped, normal polarity
      send_idle_pct <= 66;
      recv_idle_pct <= 28;
      write_start_on(1'b1);
      queue_random(RANDOM_PER_PHASE);
      wait_drained();

      // phase 3: no idling; partway in, the sink holds off long enough for
      // the output register to fill and the block to stall its input
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      write_start_on(1'b0);
      queue_random(RANDOM_PER_PHASE);
      while (responses_seen < requests_queued - RANDOM_PER_PHASE + 80) @(negedge clock);
      stall_left <= 80;
      wait_drained();

      // let any stray response surface before the verdict
      repeat (8) @(negedge clock);
      if (expected_readouts.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected responses never arrived", $time,
                  expected_readouts.size());
      end

      $display("covered %0d requests in directed and three random phases, start_on 1/0/1/0",
               requests_queued);
      $display("expiries %0d, peak hours %0d, failures %0d", expiries_seen, hours_peak,
               fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/ctsw_pkg.sv
src/ctsw_channel_if.sv
src/ctsw_update.sv
src/countdown_time_switch.sv
bench/testbench.sv
